@@ hdl/cau_pkg.sv @@
// Package for the complex arithmetic unit.
// Holds operation and status codes, the word types of both channels and the
// control struct that travels down the pipeline. No dependencies.
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

    typedef struct packed {
        t_op                           operation;
        logic signed [DATA_WIDTH-1:0]  a_real;
        logic signed [DATA_WIDTH-1:0]  a_imag;
        logic signed [DATA_WIDTH-1:0]  b_real;
        logic signed [DATA_WIDTH-1:0]  b_imag;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  res_real;
        logic signed [DATA_WIDTH-1:0]  res_imag;
        t_status                       status;
    } t_out_word;

    typedef struct packed {
        logic valid;
        logic is_div;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
    } t_ctl;

endpackage

@@ hdl/cau_front.sv @@
// Front pipeline of the complex arithmetic unit: operand capture, products,
// cross sums, magnitudes and divide setup (five register stages).
// Depends on cau_pkg.
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS,
    parameter int CW        = 3 * cau_pkg::DATA_WIDTH + FRAC_BITS + 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  cau_pkg::t_in_word                 i_word,
    output cau_pkg::t_ctl                     o_ctl,
    output logic [CW-1:0]                     o_rem_re,
    output logic [CW-1:0]                     o_rem_im,
    output logic [2*cau_pkg::DATA_WIDTH-1:0]  o_den
);
    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int MW = 2 * W + 1;

    // stage A
    logic                 r_a_vld;
    cau_pkg::t_op         r_a_op;
    logic signed [W-1:0]  r_ar, r_ai, r_br, r_bi;
    // stage B
    logic                 r_b_vld;
    cau_pkg::t_op         r_b_op;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_sq_r, r_sq_i;
    logic signed [W:0]    r_s_re, r_s_im;
    // stage C
    logic                 r_c_vld;
    cau_pkg::t_op         r_c_op;
    logic signed [MW-1:0] r_v_re, r_v_im;
    logic [PW-1:0]        r_c_den;
    // stage D
    logic                 r_d_vld;
    logic                 r_d_div;
    logic                 r_d_dz;
    logic                 r_d_neg_re, r_d_neg_im;
    logic [MW-1:0]        r_d_mag_re, r_d_mag_im;
    logic [PW-1:0]        r_d_den;
    // stage E
    cau_pkg::t_ctl        r_e_ctl;
    logic [CW-1:0]        r_e_rem_re, r_e_rem_im;
    logic [PW-1:0]        r_e_den;

    logic signed [MW-1:0] n_v_re, n_v_im;
    logic signed [MW-1:0] w_t_re, w_t_im;
    logic [MW-1:0]        w_m_re, w_m_im;
    logic                 w_dz;
    logic [CW-1:0]        n_rem_re, n_rem_im;
    logic [CW-1:0]        w_den_top;
    cau_pkg::t_ctl        n_ctl;

    always_comb begin
        case (r_b_op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
                n_v_re = MW'(r_s_re);
                n_v_im = MW'(r_s_im);
            end
            cau_pkg::OP_MUL: begin
                n_v_re = MW'(r_p_rr) - MW'(r_p_ii);
                n_v_im = MW'(r_p_ri) + MW'(r_p_ir);
            end
            default: begin
                n_v_re = MW'(r_p_rr) + MW'(r_p_ii);
                n_v_im = MW'(r_p_ir) - MW'(r_p_ri);
            end
        endcase
    end

    always_comb begin
        w_t_re = (r_c_op == cau_pkg::OP_MUL) ? (r_v_re >>> FRAC_BITS) : r_v_re;
        w_t_im = (r_c_op == cau_pkg::OP_MUL) ? (r_v_im >>> FRAC_BITS) : r_v_im;
        w_m_re = w_t_re[MW-1] ? MW'(-w_t_re) : MW'(w_t_re);
        w_m_im = w_t_im[MW-1] ? MW'(-w_t_im) : MW'(w_t_im);
        w_dz   = (r_c_op == cau_pkg::OP_DIV) && (r_c_den == '0);
    end

    always_comb begin
        w_den_top = CW'(r_d_den) << W;
        n_rem_re  = r_d_div ? (CW'(r_d_mag_re) << FRAC_BITS) : CW'(r_d_mag_re);
        n_rem_im  = r_d_div ? (CW'(r_d_mag_im) << FRAC_BITS) : CW'(r_d_mag_im);
        n_ctl.valid  = r_d_vld;
        n_ctl.is_div = r_d_div;
        n_ctl.dz     = r_d_dz;
        n_ctl.neg_re = r_d_neg_re;
        n_ctl.neg_im = r_d_neg_im;
        n_ctl.ovf_re = r_d_div && (n_rem_re >= w_den_top);
        n_ctl.ovf_im = r_d_div && (n_rem_im >= w_den_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_ctl <= '0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_op <= i_word.operation;
            r_ar   <= i_word.a_real;
            r_ai   <= i_word.a_imag;
            r_br   <= i_word.b_real;
            r_bi   <= i_word.b_imag;

            r_b_op <= r_a_op;
            r_p_rr <= PW'(r_ar) * PW'(r_br);
            r_p_ii <= PW'(r_ai) * PW'(r_bi);
            r_p_ri <= PW'(r_ar) * PW'(r_bi);
            r_p_ir <= PW'(r_ai) * PW'(r_br);
            r_sq_r <= PW'(r_br) * PW'(r_br);
            r_sq_i <= PW'(r_bi) * PW'(r_bi);
            if (r_a_op == cau_pkg::OP_SUB) begin
                r_s_re <= (W+1)'(r_ar) - (W+1)'(r_br);
                r_s_im <= (W+1)'(r_ai) - (W+1)'(r_bi);
            end else begin
                r_s_re <= (W+1)'(r_ar) + (W+1)'(r_br);
                r_s_im <= (W+1)'(r_ai) + (W+1)'(r_bi);
            end

            r_c_op  <= r_b_op;
            r_v_re  <= n_v_re;
            r_v_im  <= n_v_im;
            r_c_den <= PW'(unsigned'(r_sq_r) + unsigned'(r_sq_i));

            r_d_div    <= (r_c_op == cau_pkg::OP_DIV) && !w_dz;
            r_d_dz     <= w_dz;
            r_d_neg_re <= w_t_re[MW-1] && !w_dz;
            r_d_neg_im <= w_t_im[MW-1] && !w_dz;
            r_d_mag_re <= w_dz ? '0 : w_m_re;
            r_d_mag_im <= w_dz ? '0 : w_m_im;
            r_d_den    <= r_c_den;

            r_e_rem_re <= n_rem_re;
            r_e_rem_im <= n_rem_im;
            r_e_den    <= r_d_den;
        end
    end

    assign o_ctl    = r_e_ctl;
    assign o_rem_re = r_e_rem_re;
    assign o_rem_im = r_e_rem_im;
    assign o_den    = r_e_den;

endmodule

@@ hdl/cau_div_cell.sv @@
// One cell of the divide chain: resolves one quotient bit of both parts by
// restoring subtraction and hands remainder, quotient and divisor on.
// Depends on cau_pkg.
module cau_div_cell #(
    parameter int CW    = 3 * cau_pkg::DATA_WIDTH + cau_pkg::FRAC_BITS + 2,
    parameter int SHIFT = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  cau_pkg::t_ctl                     i_ctl,
    input  logic [CW-1:0]                     i_rem_re,
    input  logic [CW-1:0]                     i_rem_im,
    input  logic [cau_pkg::DATA_WIDTH-1:0]    i_q_re,
    input  logic [cau_pkg::DATA_WIDTH-1:0]    i_q_im,
    input  logic [2*cau_pkg::DATA_WIDTH-1:0]  i_den,
    output cau_pkg::t_ctl                     o_ctl,
    output logic [CW-1:0]                     o_rem_re,
    output logic [CW-1:0]                     o_rem_im,
    output logic [cau_pkg::DATA_WIDTH-1:0]    o_q_re,
    output logic [cau_pkg::DATA_WIDTH-1:0]    o_q_im,
    output logic [2*cau_pkg::DATA_WIDTH-1:0]  o_den
);
    localparam int W = cau_pkg::DATA_WIDTH;

    cau_pkg::t_ctl  r_ctl;
    logic [CW-1:0]  r_rem_re, r_rem_im;
    logic [W-1:0]   r_q_re, r_q_im;
    logic [2*W-1:0] r_den;

    logic [CW-1:0]  w_dsh;
    logic [CW:0]    w_diff_re, w_diff_im;
    logic           w_take_re, w_take_im;
    logic [W-1:0]   w_bit;

    always_comb begin
        w_dsh     = CW'(i_den) << SHIFT;
        w_diff_re = {1'b0, i_rem_re} - {1'b0, w_dsh};
        w_diff_im = {1'b0, i_rem_im} - {1'b0, w_dsh};
        w_take_re = i_ctl.is_div && !w_diff_re[CW];
        w_take_im = i_ctl.is_div && !w_diff_im[CW];
        w_bit     = W'(1) << SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_re <= w_take_re ? w_diff_re[CW-1:0] : i_rem_re;
            r_rem_im <= w_take_im ? w_diff_im[CW-1:0] : i_rem_im;
            r_q_re   <= w_take_re ? (i_q_re | w_bit) : i_q_re;
            r_q_im   <= w_take_im ? (i_q_im | w_bit) : i_q_im;
            r_den    <= i_den;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;
    assign o_den    = r_den;

endmodule

@@ hdl/complex_arithmetic_unit_top.sv @@
// Top level of the complex arithmetic unit: front pipeline, divide cell chain,
// saturation and output register. Depends on cau_pkg, cau_front, cau_div_cell.
//
// Input channel i_in_valid / o_in_ready carries one word: operation code and
// two complex Q3.12 operands. Output channel o_out_valid / i_out_ready carries
// the result parts and a status (ok, divide by zero, saturated).
// Every operation takes the same path: 5 front stages (capture, products, cross
// sums, magnitudes, divide setup), then one divide cell per result bit
// (DATA_WIDTH cells, 16), then the output register. A new word is accepted
// every cycle while the receiver does not stall.
// Multiply floors the scaled product; divide truncates toward zero. Any part
// out of range clamps and reports saturation; a zero divisor gives zero parts.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_in_ready drops in the same cycle; no word is lost or repeated.
// Reset (synchronous, active low) empties the pipeline; no results are pending.
module complex_arithmetic_unit_top #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cau_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cau_pkg::t_out_word o_out_word
);
    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int MW = 2 * W + 1;
    localparam int CW = 3 * W + FRAC_BITS + 2;

    logic w_en;

    cau_pkg::t_ctl  w_ctl    [0:W];
    logic [CW-1:0]  w_rem_re [0:W];
    logic [CW-1:0]  w_rem_im [0:W];
    logic [W-1:0]   w_q_re   [0:W];
    logic [W-1:0]   w_q_im   [0:W];
    logic [2*W-1:0] w_den    [0:W];

    logic               r_out_vld;
    cau_pkg::t_out_word r_out_word;
    cau_pkg::t_out_word n_out_word;
    logic               w_sat_re, w_sat_im;
    logic [W-1:0]       w_val_re, w_val_im;

    function automatic logic [W:0] f_pack(input logic neg, input logic ovf,
                                          input logic [MW-1:0] mag);
        logic [MW-1:0] lim;
        logic          sat;
        logic [W-1:0]  val;
        lim = MW'({1'b0, {(W-1){1'b1}}});
        sat = ovf || (neg ? (mag > lim + MW'(1)) : (mag > lim));
        if (sat) begin
            val = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            val = neg ? W'(-mag[W-1:0]) : mag[W-1:0];
        end
        return {sat, val};
    endfunction

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    cau_front #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_word   (i_in_word),
        .o_ctl    (w_ctl[0]),
        .o_rem_re (w_rem_re[0]),
        .o_rem_im (w_rem_im[0]),
        .o_den    (w_den[0])
    );

    assign w_q_re[0] = '0;
    assign w_q_im[0] = '0;

    for (genvar k = 0; k < W; k++) begin : g_cell
        cau_div_cell #(
            .CW    (CW),
            .SHIFT (W - 1 - k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_ctl    (w_ctl[k]),
            .i_rem_re (w_rem_re[k]),
            .i_rem_im (w_rem_im[k]),
            .i_q_re   (w_q_re[k]),
            .i_q_im   (w_q_im[k]),
            .i_den    (w_den[k]),
            .o_ctl    (w_ctl[k+1]),
            .o_rem_re (w_rem_re[k+1]),
            .o_rem_im (w_rem_im[k+1]),
            .o_q_re   (w_q_re[k+1]),
            .o_q_im   (w_q_im[k+1]),
            .o_den    (w_den[k+1])
        );
    end

    always_comb begin
        logic [MW-1:0] mag_re;
        logic [MW-1:0] mag_im;
        mag_re = w_ctl[W].is_div ? MW'(w_q_re[W]) : w_rem_re[W][MW-1:0];
        mag_im = w_ctl[W].is_div ? MW'(w_q_im[W]) : w_rem_im[W][MW-1:0];
        {w_sat_re, w_val_re} = f_pack(w_ctl[W].neg_re, w_ctl[W].ovf_re, mag_re);
        {w_sat_im, w_val_im} = f_pack(w_ctl[W].neg_im, w_ctl[W].ovf_im, mag_im);
        n_out_word.res_real = w_val_re;
        n_out_word.res_imag = w_val_im;
        if (w_ctl[W].dz) begin
            n_out_word.status = cau_pkg::ST_DIV_ZERO;
        end else if (w_sat_re || w_sat_im) begin
            n_out_word.status = cau_pkg::ST_SAT;
        end else begin
            n_out_word.status = cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_ctl[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == cau_pkg::ST_DIV_ZERO
        |-> o_out_word.res_real == '0 && o_out_word.res_imag == '0)
        else $error("divide by zero with nonzero result");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == cau_pkg::ST_SAT
        |-> o_out_word.res_real == {1'b1, {(W-1){1'b0}}}
            || o_out_word.res_real == {1'b0, {(W-1){1'b1}}}
            || o_out_word.res_imag == {1'b1, {(W-1){1'b0}}}
            || o_out_word.res_imag == {1'b0, {(W-1){1'b1}}})
        else $error("saturation status without clamped part");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output stalled");
`endif

endmodule

@@ verif/tb.sv @@
// Testbench for complex_arithmetic_unit_top: directed and random words on the
// input channel, results checked against an in-bench fixed-point predictor.
// Depends on cau_pkg and the RTL of the complex arithmetic unit.
module tb;

    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int FB = cau_pkg::FRAC_BITS;
    localparam longint MAXV = (64'sd1 <<< (W - 1)) - 1;
    localparam longint MINV = -(64'sd1 <<< (W - 1));

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    cau_pkg::t_in_word   i_in_word;
    logic                o_out_valid;
    logic                i_out_ready;
    cau_pkg::t_out_word  o_out_word;

    cau_pkg::t_out_word  expected_q[$];
    int                  errors;
    logic                stall_on;

    complex_arithmetic_unit_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint clamp_part(longint v, ref bit sat);
        if (v > MAXV) begin
            sat = 1'b1;
            return MAXV;
        end
        if (v < MINV) begin
            sat = 1'b1;
            return MINV;
        end
        return v;
    endfunction

    // floor(|n| * 2^FB / d) with sign of n; capped far above the output range
    function automatic longint div_part(longint n, longint d);
        longint m;
        longint q;
        m = (n < 0) ? -n : n;
        q = (m / d > (64'sd1 <<< 33)) ? (64'sd1 <<< 34) : ((m <<< FB) / d);
        return (n < 0) ? -q : q;
    endfunction

    function automatic cau_pkg::t_out_word complex_result(cau_pkg::t_in_word w);
        cau_pkg::t_out_word r;
        longint ar, ai, br, bi, re, im, den;
        bit sat;
        ar = w.a_real;
        ai = w.a_imag;
        br = w.b_real;
        bi = w.b_imag;
        sat = 1'b0;
        re = 0;
        im = 0;
        case (w.operation)
            cau_pkg::OP_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            cau_pkg::OP_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            cau_pkg::OP_MUL: begin
                re = (ar * br - ai * bi) >>> FB;
                im = (ar * bi + ai * br) >>> FB;
            end
            default: begin
                den = br * br + bi * bi;
                if (den != 0) begin
                    re = div_part(ar * br + ai * bi, den);
                    im = div_part(ai * br - ar * bi, den);
                end
            end
        endcase
        r.res_real = W'(clamp_part(re, sat));
        r.res_imag = W'(clamp_part(im, sat));
        if (w.operation == cau_pkg::OP_DIV && br == 0 && bi == 0) begin
            r.status = cau_pkg::ST_DIV_ZERO;
        end else begin
            r.status = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
        return r;
    endfunction

    task automatic send_word(cau_pkg::t_in_word w);
        int gap;
        if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_q.push_back(complex_result(w));
    endtask

    function automatic cau_pkg::t_in_word make_word(cau_pkg::t_op op, longint ar,
                                                    longint ai, longint br,
                                                    longint bi);
        cau_pkg::t_in_word w;
        w.operation = op;
        w.a_real = W'(ar);
        w.a_imag = W'(ai);
        w.b_real = W'(br);
        w.b_imag = W'(bi);
        return w;
    endfunction

    function automatic logic [W-1:0] rand_part();
        case ($urandom_range(0, 5))
            0: return W'(MAXV);
            1: return W'(MINV);
            2: return W'($urandom_range(0, 64)) - W'(32);
            3: return W'($urandom_range(0, 8191)) - W'(4096);
            default: return W'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        cau_pkg::t_op op;
        for (int k = 0; k < 4; k++) begin
            op = cau_pkg::t_op'(k);
            send_word(make_word(op, MAXV, MAXV, MAXV, MAXV));
            send_word(make_word(op, MINV, MINV, MINV, MINV));
            send_word(make_word(op, MAXV, MINV, MINV, MAXV));
            send_word(make_word(op, 4096, -4096, 2048, 4096));
        end
        send_word(make_word(cau_pkg::OP_DIV, 1234, -77, 0, 0));
        send_word(make_word(cau_pkg::OP_DIV, MINV, MAXV, 0, 0));
        send_word(make_word(cau_pkg::OP_DIV, MAXV, 0, 1, 0));
        send_word(make_word(cau_pkg::OP_DIV, -1, -1, 0, 3));
        send_word(make_word(cau_pkg::OP_MUL, -1, 0, 1, 0));
        send_word(make_word(cau_pkg::OP_MUL, 0, 0, 0, 0));
        send_word(make_word(cau_pkg::OP_DIV, 0, 0, MINV, MINV));
    endtask

    task automatic test_random(int count);
        cau_pkg::t_in_word w;
        int burst;
        int n;
        n = 0;
        while (n < count) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && n < count; k++) begin
                w.operation = cau_pkg::t_op'($urandom_range(0, 3));
                w.a_real = rand_part();
                w.a_imag = rand_part();
                w.b_real = ($urandom_range(0, 15) == 0) ? '0 : rand_part();
                w.b_imag = ($urandom_range(0, 15) == 0) ? '0 : rand_part();
                send_word(w);
                n++;
            end
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // receiver stall pattern: alternating free-running and stalling stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
            stall_on    <= 1'b0;
        end else begin
            if ($urandom_range(0, 31) == 0) stall_on <= ~stall_on;
            i_out_ready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %h", $time, o_out_word);
            end else begin
                cau_pkg::t_out_word e;
                e = expected_q.pop_front();
                if (o_out_word.res_real !== e.res_real) begin
                    errors++;
                    $display("%0t: res_real expected %0d actual %0d", $time,
                             e.res_real, o_out_word.res_real);
                end
                if (o_out_word.res_imag !== e.res_imag) begin
                    errors++;
                    $display("%0t: res_imag expected %0d actual %0d", $time,
                             e.res_imag, o_out_word.res_imag);
                end
                if (o_out_word.status !== e.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             e.status, o_out_word.status);
                end
            end
        end
    end

    initial begin
        errors     = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_random(430);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (W + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
